/* rtl/minmax_envelope_decimator_top_assert.svh */
// Assertion macros for the min/max envelope decimator.
// Taken in by every module that asserts; expects clk and rst_n in scope.
`ifndef MINMAX_ENVELOPE_DECIMATOR_TOP_ASSERT_SVH
`define MINMAX_ENVELOPE_DECIMATOR_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MMED_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("mmed: same-cycle check failed");
`define MMED_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("mmed: next-cycle check failed");
`else
`define MMED_ASSERT_IMP(name, pre, post)
`define MMED_ASSERT_NXT(name, pre, post)
`endif
`endif

/* rtl/mmed_pkg.sv */
// Shared constants, codes and the command word of the envelope decimator.
// No dependencies.
package mmed_pkg;

  localparam int MAX_POINTS_DEF      = 4096;
  localparam int PIXEL_FRAC_BITS_DEF = 8;
  localparam int CFG_W               = 12;
  localparam int FIFO_DEPTH          = 4;

  localparam logic [CFG_W-1:0] PLOT_WIDTH_RST  = 12'd640;
  localparam logic [CFG_W-1:0] PLOT_HEIGHT_RST = 12'd480;

  // floor(n / 20) = (floor(n / 4) * PAD_RECIP5) >> 34 for any 33-bit n
  localparam logic [31:0] PAD_RECIP5 = 32'hCCCCCCCD;
  localparam int PAD_RND     = 10;
  localparam int HALF_Q16    = 32768;
  localparam int FIELD20_MAX = 1048575;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NONINC   = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic REG_PLOT_WIDTH  = 1'b0;
  localparam logic REG_PLOT_HEIGHT = 1'b1;

  typedef struct packed {
    logic              is_pull;
    logic              first;
    logic              ok;
    logic [1:0]        status;
    logic signed [31:0] smp_time;
    logic signed [31:0] smp_value;
  } cmd_t;

endpackage

/* rtl/minmax_envelope_decimator_top.sv */
// A pull that maps a point directly reads it from the store, forms the x/y products and
// runs the x and the y divide (QW = max(29, 13 + PIXEL_FRAC_BITS)); a pull that opens a
// column of k points first divides for its column and walks the k points, and the first
// pull of a set first sets up the axes. The back end handles one word at a time,
// bounded by the shared bit-serial divider; while idle it stores one queued load per cycle.
// Reset (rst_n low, synchronous) empties the queue and the set, plot size to 640 x 480.
module minmax_envelope_decimator_top import mmed_pkg::*; #(
  parameter int MAX_POINTS      = MAX_POINTS_DEF,
  parameter int PIXEL_FRAC_BITS = PIXEL_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic signed [31:0] in_sample_time,
  input  logic signed [31:0] in_sample_value,
  input  logic               in_last_point,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [19:0]        out_x_pos,
  output logic [19:0]        out_y_pos,
  output logic               out_vertex_valid,
  output logic               out_last_vertex,
  output logic [1:0]         out_status,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  logic [CFG_W-1:0] plot_w_r, plot_h_r;
  logic             cfg_wr;
  logic             q_push, q_pop, q_empty, q_full;
  cmd_t             q_in, q_head;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plot_w_r <= PLOT_WIDTH_RST;
      plot_h_r <= PLOT_HEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_PLOT_WIDTH:  plot_w_r <= cfg_pwdata[CFG_W-1:0];
        REG_PLOT_HEIGHT: plot_h_r <= cfg_pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_PLOT_WIDTH:  cfg_prdata = 32'(plot_w_r);
      REG_PLOT_HEIGHT: cfg_prdata = 32'(plot_h_r);
      default:         cfg_prdata = '0;
    endcase
  end

  mmed_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_sample_time (in_sample_time),
    .in_sample_value(in_sample_value),
    .in_last_point  (in_last_point),
    .q_full         (q_full),
    .push           (q_push),
    .push_cmd       (q_in)
  );

  mmed_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(q_in),
    .pop     (q_pop),
    .head    (q_head),
    .empty   (q_empty),
    .full    (q_full)
  );

  mmed_back #(
    .MAX_POINTS     (MAX_POINTS),
    .PIXEL_FRAC_BITS(PIXEL_FRAC_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_w           (plot_w_r),
    .cfg_h           (plot_h_r),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_x_pos       (out_x_pos),
    .out_y_pos       (out_y_pos),
    .out_vertex_valid(out_vertex_valid),
    .out_last_vertex (out_last_vertex),
    .out_status      (out_status)
  );
endmodule

/* rtl/mmed_div.sv */
// Restoring divider, one quotient bit per cycle; quotient must fit QW bits.
// Depends on nothing.
module mmed_div #(
  parameter int NW = 55,
  parameter int DW = 34,
  parameter int QW = 29
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic          done,
  output logic [QW-1:0] quo
);
  localparam int SW = (NW > DW + QW) ? NW : DW + QW;
  localparam int KW = $clog2(QW + 1);

  logic [SW-1:0] rem_r, dsh_r;
  logic [QW-1:0] quo_r;
  logic [KW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic          fits;

  assign fits = rem_r >= dsh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == KW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= KW'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == KW'(1)) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= SW'(num);
      dsh_r <= SW'(den) << (QW - 1);
      quo_r <= '0;
    end else if (busy_r) begin
      if (fits) rem_r <= rem_r - dsh_r;
      quo_r <= {quo_r[QW-2:0], fits};
      dsh_r <= dsh_r >> 1;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;
endmodule

/* rtl/mmed_fifo.sv */
// Short command queue between the classifier and the vertex engine.
// Depends on mmed_pkg.
module mmed_fifo import mmed_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);
  localparam int PW = $clog2(FIFO_DEPTH);

  cmd_t        slot_r [FIFO_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      fill_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop) fill_r <= fill_r + 1'b1;
      else if (pop && !push) fill_r <= fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_cmd;
  end

  assign head  = slot_r[rp_r];
  assign empty = (fill_r == '0);
  assign full  = (fill_r == (PW+1)'(FIFO_DEPTH));
endmodule

/* rtl/mmed_front.sv */
// Input side: checks time order and store room, tracks set status, queues commands.
// Depends on mmed_pkg.
module mmed_front import mmed_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic signed [31:0] in_sample_time,
  input  logic signed [31:0] in_sample_value,
  input  logic               in_last_point,
  input  logic               q_full,
  output logic               push,
  output cmd_t               push_cmd
);
  localparam int CW = $clog2(MAX_POINTS + 1);

  logic               closed_r;
  logic [CW-1:0]      cnt_r, cnt_eff;
  logic [1:0]         status_r, status_eff;
  logic signed [31:0] last_t_r;
  logic               acc, bad_time, no_room;

  assign in_stall   = q_full;
  assign acc        = in_valid && !q_full;
  // a load after a closed set starts afresh
  assign cnt_eff    = closed_r ? '0 : cnt_r;
  assign status_eff = closed_r ? ST_OK : status_r;
  assign bad_time   = (cnt_eff != '0) && (in_sample_time <= last_t_r);
  assign no_room    = (cnt_eff == CW'(MAX_POINTS));

  always_comb begin
    push_cmd           = '0;
    push_cmd.smp_time  = in_sample_time;
    push_cmd.smp_value = in_sample_value;
    push_cmd.status    = status_r;
    push               = 1'b0;
    if (acc) begin
      if (in_req_type) begin
        push             = 1'b1;
        push_cmd.is_pull = 1'b1;
        push_cmd.ok      = closed_r && (status_r == ST_OK) && (cnt_r != '0);
      end else if (!bad_time && !no_room) begin
        push           = 1'b1;
        push_cmd.first = (cnt_eff == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      closed_r <= 1'b0;
      cnt_r    <= '0;
      status_r <= ST_OK;
      last_t_r <= '0;
    end else if (acc && !in_req_type) begin
      closed_r <= in_last_point;
      if (bad_time) begin
        cnt_r    <= cnt_eff;
        status_r <= (status_eff == ST_OK) ? ST_NONINC : status_eff;
      end else if (no_room) begin
        cnt_r    <= cnt_eff;
        status_r <= (status_eff == ST_OK) ? ST_OVERFLOW : status_eff;
      end else begin
        cnt_r    <= cnt_eff + 1'b1;
        status_r <= status_eff;
        last_t_r <= in_sample_time;
      end
    end
  end
endmodule

/* rtl/mmed_back.sv */
// Vertex engine: point store, axis setup, column walk, x/y mapping, result register.
// Depends on mmed_pkg, mmed_div and the assertion macro header.
`include "minmax_envelope_decimator_top_assert.svh"
module mmed_back import mmed_pkg::*; #(
  parameter int MAX_POINTS      = MAX_POINTS_DEF,
  parameter int PIXEL_FRAC_BITS = PIXEL_FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CFG_W-1:0] cfg_w,
  input  logic [CFG_W-1:0] cfg_h,
  input  logic             q_empty,
  input  cmd_t             q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [19:0]      out_x_pos,
  output logic [19:0]      out_y_pos,
  output logic             out_vertex_valid,
  output logic             out_last_vertex,
  output logic [1:0]       out_status
);
  localparam int F  = PIXEL_FRAC_BITS;
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int NW = 47 + F;
  localparam int DW = 34;
  localparam int QW = (13 + F > 29) ? 13 + F : 29;

  typedef enum logic [20:0] {
    S_IDLE   = 21'h000001, S_AXT    = 21'h000002, S_AXT_W  = 21'h000004,
    S_AXV    = 21'h000008, S_AXV_W  = 21'h000010, S_DISP   = 21'h000020,
    S_COL_DX = 21'h000040, S_COL_DV = 21'h000080, S_COL_W  = 21'h000100,
    S_COL_BD = 21'h000200, S_WRD    = 21'h000400, S_WDX    = 21'h000800,
    S_WCMP   = 21'h001000, S_WEND   = 21'h002000, S_MAP_DX = 21'h004000,
    S_MAP_ML = 21'h008000, S_MAPX   = 21'h010000, S_MAPX_W = 21'h020000,
    S_MAPY   = 21'h040000, S_MAPY_W = 21'h080000, S_OUT    = 21'h100000
  } state_t;

  state_t state_r, state_nxt;

  // point store
  logic signed [31:0] tmem [MAX_POINTS];
  logic signed [31:0] vmem [MAX_POINTS];
  logic               we, rd_en;
  logic [AW-1:0]      waddr, rd_addr;
  logic signed [31:0] rd_t_r, rd_v_r;

  logic [CW-1:0]      cnt_r, cursor_r, pending_r, end_r;
  logic [AW-1:0]      lo_i_r, hi_i_r;
  logic signed [31:0] lo_v_r, hi_v_r;
  logic signed [31:0] first_t_r, last_t_r, vlo_r, vhi_r;
  logic               axes_ok_r, last_flag_r, lastcol_r;
  logic signed [33:0] tmin_r, vmin_r;
  logic [32:0]        tspan_r, vspan_r;
  logic [32:0]        dx_r, dy_r;
  logic [44:0]        px_r, py_r;
  logic [CFG_W-1:0]   col_r;
  logic [45:0]        bound_r;
  logic [19:0]        res_x_r, res_y_r;
  logic               res_vv_r, res_last_r;
  logic [1:0]         res_stat_r;
  logic               out_valid_r, out_vv_r, out_last_r;
  logic [19:0]        out_x_r, out_y_r;
  logic [1:0]         out_stat_r;

  // divider
  logic               div_start, div_busy, div_done;
  logic [NW-1:0]      div_num;
  logic [DW-1:0]      div_den;
  logic [QW-1:0]      div_q;

  // axis pad: divide by twenty through a reciprocal product
  logic [32:0]        pad_num;
  logic [62:0]        pad_prod_r;

  // helpers
  logic [44:0]        mul_w;
  logic [31:0]        abs_t, abs_lo;
  logic [32:0]        vdiff, pad_q, pad_fl;
  logic               v_wide, out_free, map_all;
  logic signed [33:0] dx_s, dy_s;
  logic [AW-1:0]      first_i, second_i;
  logic [QW-1:0]      full_q, ydiff;

  assign mul_w    = 45'(dx_r) * 45'(cfg_w);
  assign abs_t    = first_t_r[31] ? (~first_t_r + 32'd1) : first_t_r;
  assign abs_lo   = vlo_r[31] ? (~vlo_r + 32'd1) : vlo_r;
  assign v_wide   = vhi_r > vlo_r;
  assign vdiff    = 33'(34'(vhi_r) - 34'(vlo_r));
  assign pad_q    = 33'(pad_prod_r[62:34]);
  assign pad_fl   = (pad_q < 33'(HALF_Q16)) ? 33'(HALF_Q16) : pad_q;
  assign out_free = !out_valid_r || !out_stall;
  assign map_all  = (cfg_w == '0) || (32'(cnt_r) <= 32'(cfg_w));
  assign dx_s     = 34'(rd_t_r) - tmin_r;
  assign dy_s     = 34'(rd_v_r) - vmin_r;
  assign first_i  = (lo_i_r < hi_i_r) ? lo_i_r : hi_i_r;
  assign second_i = (lo_i_r < hi_i_r) ? hi_i_r : lo_i_r;
  assign full_q   = QW'(cfg_h) << F;
  assign ydiff    = full_q - div_q;

  mmed_div #(.NW(NW), .DW(DW), .QW(QW)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .busy (div_busy),
    .done (div_done),
    .quo  (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    we        = 1'b0;
    waddr     = q_head.first ? '0 : cnt_r[AW-1:0];
    rd_en     = 1'b0;
    rd_addr   = cursor_r[AW-1:0];
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    pad_num   = '0;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (!q_head.is_pull) we = 1'b1;
          else if (!q_head.ok) state_nxt = S_OUT;
          else if (axes_ok_r) state_nxt = S_DISP;
          else state_nxt = S_AXT;
        end
      end
      S_AXT: begin
        if (last_t_r > first_t_r) state_nxt = S_AXV;
        else begin
          pad_num   = 33'(abs_t) + 33'(PAD_RND);
          state_nxt = S_AXT_W;
        end
      end
      S_AXT_W: state_nxt = S_AXV;
      S_AXV: begin
        pad_num   = v_wide ? vdiff + 33'(PAD_RND) : 33'(abs_lo) + 33'(PAD_RND);
        state_nxt = S_AXV_W;
      end
      S_AXV_W: state_nxt = S_DISP;
      S_DISP: begin
        if (pending_r != '0) begin
          rd_en     = 1'b1;
          rd_addr   = AW'(pending_r - 1'b1);
          state_nxt = S_MAP_DX;
        end else if (cursor_r >= cnt_r) begin
          state_nxt = S_OUT;
        end else begin
          rd_en     = 1'b1;
          state_nxt = map_all ? S_MAP_DX : S_COL_DX;
        end
      end
      S_COL_DX: state_nxt = S_COL_DV;
      S_COL_DV: begin
        div_start = 1'b1;
        div_num   = NW'(mul_w);
        div_den   = DW'(tspan_r);
        state_nxt = S_COL_W;
      end
      S_COL_W:  if (div_done) state_nxt = S_COL_BD;
      S_COL_BD: state_nxt = S_WRD;
      S_WRD: begin
        if (end_r >= cnt_r) state_nxt = S_WEND;
        else begin
          rd_en     = 1'b1;
          rd_addr   = end_r[AW-1:0];
          state_nxt = S_WDX;
        end
      end
      S_WDX: state_nxt = S_WCMP;
      S_WCMP: begin
        if (lastcol_r || ({1'b0, mul_w} < bound_r)) state_nxt = S_WRD;
        else state_nxt = S_WEND;
      end
      S_WEND: begin
        rd_en     = 1'b1;
        rd_addr   = first_i;
        state_nxt = S_MAP_DX;
      end
      S_MAP_DX: state_nxt = S_MAP_ML;
      S_MAP_ML: state_nxt = S_MAPX;
      S_MAPX: begin
        div_start = 1'b1;
        div_num   = (NW'(px_r) << (F + 1)) + NW'(tspan_r);
        div_den   = {tspan_r, 1'b0};
        state_nxt = S_MAPX_W;
      end
      S_MAPX_W: if (div_done) state_nxt = S_MAPY;
      S_MAPY: begin
        div_start = 1'b1;
        div_num   = (NW'(py_r) << (F + 1)) + NW'(vspan_r);
        div_den   = {vspan_r, 1'b0};
        state_nxt = S_MAPY_W;
      end
      S_MAPY_W: if (div_done) state_nxt = S_OUT;
      S_OUT:    if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      tmem[waddr] <= q_head.smp_time;
      vmem[waddr] <= q_head.smp_value;
    end
    if (rd_en) begin
      rd_t_r <= tmem[rd_addr];
      rd_v_r <= vmem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      cursor_r    <= '0;
      pending_r   <= '0;
      axes_ok_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (we) begin
            axes_ok_r <= 1'b0;
            cnt_r     <= CW'(waddr) + 1'b1;
            if (q_head.first) begin
              cursor_r  <= '0;
              pending_r <= '0;
            end
          end
        end
        S_AXV_W: axes_ok_r <= 1'b1;
        S_DISP: begin
          if (pending_r != '0) pending_r <= '0;
          else if (cursor_r < cnt_r && map_all) cursor_r <= cursor_r + 1'b1;
        end
        S_WEND: begin
          cursor_r <= end_r;
          if (second_i != first_i) pending_r <= CW'(second_i) + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (we) begin
          last_t_r <= q_head.smp_time;
          if (q_head.first) begin
            first_t_r <= q_head.smp_time;
            vlo_r     <= q_head.smp_value;
            vhi_r     <= q_head.smp_value;
          end else begin
            if (q_head.smp_value < vlo_r) vlo_r <= q_head.smp_value;
            if (q_head.smp_value > vhi_r) vhi_r <= q_head.smp_value;
          end
        end else if (!q_empty) begin
          res_x_r    <= '0;
          res_y_r    <= '0;
          res_vv_r   <= 1'b0;
          res_last_r <= 1'b0;
          res_stat_r <= q_head.ok ? ST_OK : q_head.status;
        end
      end
      S_AXT: begin
        tmin_r     <= 34'(first_t_r);
        tspan_r    <= 33'(34'(last_t_r) - 34'(first_t_r));
        pad_prod_r <= 63'(pad_num[32:2]) * 63'(PAD_RECIP5);
      end
      S_AXT_W: begin
        tmin_r  <= 34'(first_t_r) - 34'(pad_fl);
        tspan_r <= {pad_fl[31:0], 1'b0};
      end
      S_AXV: pad_prod_r <= 63'(pad_num[32:2]) * 63'(PAD_RECIP5);
      S_AXV_W: begin
        vmin_r  <= 34'(vlo_r) - 34'(v_wide ? pad_q : pad_fl);
        vspan_r <= vdiff + {(v_wide ? pad_q[31:0] : pad_fl[31:0]), 1'b0};
      end
      S_DISP: begin
        if (pending_r != '0) last_flag_r <= (cursor_r >= cnt_r);
        else last_flag_r <= (cursor_r + 1'b1 >= cnt_r);
        lo_i_r <= cursor_r[AW-1:0];
        hi_i_r <= cursor_r[AW-1:0];
        end_r  <= cursor_r;
      end
      S_COL_DX: begin
        dx_r   <= dx_s[32:0];
        lo_v_r <= rd_v_r;
        hi_v_r <= rd_v_r;
      end
      S_COL_W: begin
        if (div_done) begin
          if (div_q >= QW'(cfg_w - 1'b1)) col_r <= cfg_w - 1'b1;
          else col_r <= div_q[CFG_W-1:0];
        end
      end
      S_COL_BD: begin
        bound_r   <= 46'({1'b0, col_r} + 13'd1) * 46'(tspan_r);
        lastcol_r <= (col_r == cfg_w - 1'b1);
        end_r     <= end_r + 1'b1;
      end
      S_WDX: dx_r <= dx_s[32:0];
      S_WCMP: begin
        if (lastcol_r || ({1'b0, mul_w} < bound_r)) begin
          if (rd_v_r < lo_v_r) begin
            lo_v_r <= rd_v_r;
            lo_i_r <= end_r[AW-1:0];
          end
          if (rd_v_r > hi_v_r) begin
            hi_v_r <= rd_v_r;
            hi_i_r <= end_r[AW-1:0];
          end
          end_r <= end_r + 1'b1;
        end
      end
      S_WEND: last_flag_r <= (second_i == first_i) && (end_r >= cnt_r);
      S_MAP_DX: begin
        dx_r <= dx_s[32:0];
        dy_r <= dy_s[32:0];
      end
      S_MAP_ML: begin
        px_r <= mul_w;
        py_r <= 45'(dy_r) * 45'(cfg_h);
      end
      S_MAPX_W: begin
        if (div_done) res_x_r <= (div_q > QW'(FIELD20_MAX)) ? 20'hFFFFF : div_q[19:0];
      end
      S_MAPY_W: begin
        if (div_done) begin
          if (div_q > full_q) res_y_r <= '0;
          else res_y_r <= (ydiff > QW'(FIELD20_MAX)) ? 20'hFFFFF : ydiff[19:0];
          res_vv_r   <= 1'b1;
          res_last_r <= last_flag_r;
          res_stat_r <= ST_OK;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_x_r    <= res_x_r;
          out_y_r    <= res_y_r;
          out_vv_r   <= res_vv_r;
          out_last_r <= res_last_r;
          out_stat_r <= res_stat_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_x_pos        = out_x_r;
  assign out_y_pos        = out_y_r;
  assign out_vertex_valid = out_vv_r;
  assign out_last_vertex  = out_last_r;
  assign out_status       = out_stat_r;

  `MMED_ASSERT_IMP(a_cursor_in_set, 1'b1, cursor_r <= cnt_r)
  `MMED_ASSERT_IMP(a_pending_behind_cursor, pending_r != '0, pending_r <= cursor_r)
  `MMED_ASSERT_IMP(a_div_start_idle, div_start, !div_busy)
endmodule

/* tb/testbench.sv */
// Self-checking bench for minmax_envelope_decimator_top: point loads, vertex pulls, plot sizing.
// Depends on mmed_pkg and the top level; a scoreboard class predicts every pulled vertex.
module testbench;
  import mmed_pkg::*;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_PULL = 1'b1;
  localparam int   STORE_DEPTH = 4096;
  localparam int   LIMIT_CYCLES = 3000000;

  typedef struct packed {
    logic [19:0] x_pos;
    logic [19:0] y_pos;
    logic        vertex_valid;
    logic        last_vertex;
    logic [1:0]  status;
  } vertex_t;

  class vertex_predictor;
    int          tstore[STORE_DEPTH];
    int          vstore[STORE_DEPTH];
    int          count, vlow, vhigh, cursor, owed;
    logic [1:0]  set_st;
    bit          closed;
    int          width = 640, height = 480;
    longint      tmin, tspan, vmin, vspan;
    vertex_t     expected_vertices[$];
    bit          drained;
    int          errors, checked;

    function void set_reg(logic idx, int val);
      if (idx == REG_PLOT_WIDTH) width = val;
      else height = val;
    endfunction

    function longint degen_pad(longint m);
      longint a, p;
      a = m < 0 ? -m : m;
      p = (a + 10) / 20;
      return p < HALF_Q16 ? HALF_Q16 : p;
    endfunction

    function void build_axes();
      longint t0, t1, p;
      t0 = tstore[0];
      t1 = tstore[count-1];
      if (t1 > t0) begin
        tmin = t0; tspan = t1 - t0;
      end else begin
        p = degen_pad(t0); tmin = t0 - p; tspan = 2 * p;
      end
      if (vhigh > vlow) begin
        p = (longint'(vhigh) - vlow + 10) / 20;
        vmin = vlow - p; vspan = (longint'(vhigh) - vlow) + 2 * p;
      end else begin
        p = degen_pad(vlow); vmin = vlow - p; vspan = 2 * p;
      end
    endfunction

    function int col_index(int i);
      longint unsigned dx, c;
      dx = longint'(tstore[i]) - tmin;
      c = (dx * width) / longint'(tspan);
      return c > width - 1 ? width - 1 : int'(c);
    endfunction

    function longint unsigned div_round(longint unsigned num, longint unsigned den);
      return (2 * num + den) / (2 * den);
    endfunction

    function void place_point(int i, ref vertex_t v);
      longint unsigned dx, dy, x, q, full, y;
      dx = longint'(tstore[i]) - tmin;
      dy = longint'(vstore[i]) - vmin;
      x = div_round((dx * width) << PIXEL_FRAC_BITS_DEF, tspan);
      full = longint'(height) << PIXEL_FRAC_BITS_DEF;
      q = div_round((dy * height) << PIXEL_FRAC_BITS_DEF, vspan);
      y = q > full ? 0 : full - q;
      v.x_pos = x > FIELD20_MAX ? 20'hFFFFF : x[19:0];
      v.y_pos = y > FIELD20_MAX ? 20'hFFFFF : y[19:0];
      v.vertex_valid = 1'b1;
    endfunction

    function void note_request(logic rt, int t, int v, logic lp);
      vertex_t e;
      int col, lo_i, hi_i, stop, first, second;
      if (rt == REQ_LOAD) begin
        if (closed) begin
          count = 0; set_st = ST_OK; cursor = 0; owed = 0; closed = 0;
        end
        if (count > 0 && t <= tstore[count-1]) begin
          if (set_st == ST_OK) set_st = ST_NONINC;
        end else if (count >= STORE_DEPTH) begin
          if (set_st == ST_OK) set_st = ST_OVERFLOW;
        end else begin
          tstore[count] = t;
          vstore[count] = v;
          if (count == 0 || v < vlow) vlow = v;
          if (count == 0 || v > vhigh) vhigh = v;
          count++;
        end
        if (lp) closed = 1;
        return;
      end
      e = '{default: '0};
      e.status = set_st;
      if (!closed || set_st != ST_OK || count == 0) begin
        // nothing to give: no vertex, status only
      end else begin
        build_axes();
        if (owed != 0) begin
          place_point(owed - 1, e);
          owed = 0;
          e.last_vertex = cursor >= count;
        end else if (cursor >= count) begin
        end else if (count <= width) begin
          place_point(cursor, e);
          cursor++;
          e.last_vertex = cursor >= count;
        end else begin
          col = col_index(cursor);
          lo_i = cursor; hi_i = cursor; stop = cursor;
          while (stop < count && col_index(stop) == col) begin
            if (vstore[stop] < vstore[lo_i]) lo_i = stop;
            if (vstore[stop] > vstore[hi_i]) hi_i = stop;
            stop++;
          end
          cursor = stop;
          first = lo_i < hi_i ? lo_i : hi_i;
          second = lo_i < hi_i ? hi_i : lo_i;
          place_point(first, e);
          if (second != first) owed = second + 1;
          else e.last_vertex = cursor >= count;
        end
      end
      drained = !e.vertex_valid || e.last_vertex;
      expected_vertices.insert(expected_vertices.size(), e);
    endfunction

    function void check_vertex(vertex_t got);
      vertex_t e;
      checked++;
      if (expected_vertices.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected vertex word x=%0d y=%0d", got.x_pos, got.y_pos);
        return;
      end
      e = expected_vertices.pop_front();
      if (got != e) begin
        errors++;
        if (errors <= 10)
          $display("vertex %0d: exp x=%0d y=%0d v=%0b l=%0b s=%0d got x=%0d y=%0d v=%0b l=%0b s=%0d",
                   checked, e.x_pos, e.y_pos, e.vertex_valid, e.last_vertex, e.status,
                   got.x_pos, got.y_pos, got.vertex_valid, got.last_vertex, got.status);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_req_type = 1'b0, in_last_point = 1'b0;
  logic signed [31:0] in_sample_time = '0, in_sample_value = '0;
  logic out_stall = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic in_stall, out_valid, out_vertex_valid, out_last_vertex, cfg_pready;
  logic [19:0] out_x_pos, out_y_pos;
  logic [1:0]  out_status;
  logic [31:0] cfg_prdata;

  vertex_predictor sb = new();
  bit  calm;
  int  stall_left, cycles, words_sent, sets_loaded, cfg_writes;

  minmax_envelope_decimator_top uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL minmax_envelope_decimator_top");
      $finish;
    end
  end

  // result side: check on acceptance, then hold off for a drawn number of cycles
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sb.check_vertex('{out_x_pos, out_y_pos, out_vertex_valid, out_last_vertex, out_status});
        stall_left = calm ? 0 : $urandom_range(0, 14);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else out_stall <= 1'b0;
    end
  end

  task automatic send_word(logic rt, int t, int v, logic lp);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= rt;
    in_sample_time <= t;
    in_sample_value <= v;
    in_last_point <= lp;
    do @(posedge clk); while (in_stall);
    sb.note_request(rt, t, v, lp);
    words_sent++;
  endtask

  task automatic pull_all(int most);
    int k;
    k = 0;
    sb.drained = 0;
    while (!sb.drained && k < most) begin
      send_word(REQ_PULL, $urandom, $urandom, 1'($urandom_range(0, 1)));
      k++;
    end
    repeat ($urandom_range(1, 2))
      send_word(REQ_PULL, $urandom, $urandom, 1'($urandom_range(0, 1)));
  endtask

  // drain every expected vertex and let in-flight loads settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_vertices.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, int val);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    sb.set_reg(idx, val);
    cfg_writes++;
  endtask

  task automatic random_set(int n);
    longint t, v, base;
    int i;
    t = longint'($signed($urandom));
    if (t > 64'sd2147483647 - longint'(n) * (1 << 20) - 1)
      t = 64'sd2147483647 - longint'(n) * (1 << 20) - 1;
    base = longint'($signed($urandom));
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 8 && i > 0)
        send_word(REQ_LOAD, int'(t - $urandom_range(0, 5) < -64'sd2147483648 ? t
                                 : t - $urandom_range(0, 5)), $urandom, 1'b0);
      if ($urandom_range(0, 99) < 5) send_word(REQ_PULL, $urandom, $urandom, 1'b0);
      v = ($urandom_range(0, 2) == 0) ? longint'($signed($urandom))
          : base + $urandom_range(0, 4000);
      send_word(REQ_LOAD, int'(t), int'(v), i == n - 1);
      t += $urandom_range(1, 1 << $urandom_range(0, 20));
    end
    sets_loaded++;
    pull_all(2 * n + 3);
  endtask

  initial begin
    int i, w, h, n;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pull on the empty set just after reset
    send_word(REQ_PULL, 0, 0, 1'b0);
    // single point: padded on both axes
    send_word(REQ_LOAD, 0, 0, 1'b1);
    pull_all(4);
    // full-range extremes of time and value
    send_word(REQ_LOAD, 32'sh80000000, 32'sh7fffffff, 1'b0);
    send_word(REQ_LOAD, 32'sh7fffffff, 32'sh80000000, 1'b1);
    pull_all(4);
    // flat value range
    for (i = 0; i < 3; i++) send_word(REQ_LOAD, i * 65536, -5 * 65536, i == 2);
    pull_all(6);
    // repeated time flags the set
    send_word(REQ_LOAD, 10, 1, 1'b0);
    send_word(REQ_LOAD, 10, 2, 1'b1);
    send_word(REQ_PULL, 0, 0, 1'b0);
    // overfill the point store
    calm = 1;
    for (i = 0; i <= STORE_DEPTH; i++) send_word(REQ_LOAD, i, $urandom, i == STORE_DEPTH);
    send_word(REQ_PULL, 0, 0, 1'b0);
    calm = 0;
    wait_idle();
    cfg_write(REG_PLOT_WIDTH, 1);
    cfg_write(REG_PLOT_HEIGHT, 4095);
    for (i = 0; i < 5; i++) send_word(REQ_LOAD, i * 100, $urandom, i == 4);
    pull_all(8);

    while (words_sent < 1400 + STORE_DEPTH) begin
      wait_idle();
      case ($urandom_range(0, 5))
        0: begin w = 4095; h = 1; end
        1: begin w = 1; h = $urandom_range(1, 4095); end
        2: begin w = $urandom_range(2, 8); h = 4095; end
        3: begin w = 640; h = 480; end
        default: begin w = $urandom_range(1, 4095); h = $urandom_range(1, 4095); end
      endcase
      cfg_write(REG_PLOT_WIDTH, w);
      cfg_write(REG_PLOT_HEIGHT, h);
      calm = $urandom_range(0, 3) == 0;
      repeat ($urandom_range(3, 8)) begin
        n = (w <= 8) ? $urandom_range(1, 40) : $urandom_range(1, 30);
        if ($urandom_range(0, 15) == 0) n = $urandom_range(50, 100);
        random_set(n);
      end
    end

    calm = 0;
    in_valid <= 1'b0;
    while (sb.expected_vertices.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d words, %0d random sets, %0d register writes, %0d vertices checked",
             words_sent, sets_loaded, cfg_writes, sb.checked);
    if (sb.errors == 0 && sb.expected_vertices.size() == 0) begin
      $display("PASS minmax_envelope_decimator_top");
    end else begin
      $display("%0d mismatches, %0d vertices outstanding", sb.errors,
               sb.expected_vertices.size());
      $display("FAIL minmax_envelope_decimator_top");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+rtl
rtl/mmed_pkg.sv
rtl/mmed_div.sv
rtl/mmed_fifo.sv
rtl/mmed_front.sv
rtl/mmed_back.sv
rtl/minmax_envelope_decimator_top.sv
tb/testbench.sv
